@@ rtl/core/swsm_pkg.sv @@
// shared types and constants for the stack with largest and second-largest tracking
// no dependencies

package swsm_pkg;

    localparam int DEPTH       = 64;
    localparam int VALUE_WIDTH = 16;
    localparam int COUNT_W     = $clog2(DEPTH + 1);

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    typedef logic [COUNT_W-1:0]            count_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    // one stack level: running max, running second max and its valid bit
    typedef struct packed {
        value_t max;
        value_t second;
        logic   valid;
    } level_t;

    typedef struct packed {
        logic push;
        logic pop;
    } shift_ctl_t;

    typedef struct packed {
        logic   opcode;
        value_t push_value;
    } req_t;

    typedef struct packed {
        value_t  top_max;
        value_t  top_second;
        logic    second_valid;
        logic    is_empty;
        status_t status;
    } rsp_t;

endpackage

@@ rtl/core/swsm_cell.sv @@
// one level of the shifting stack chain
// depends on swsm_pkg

module swsm_cell (
    input  logic               clk,
    input  swsm_pkg::shift_ctl_t shift,
    input  swsm_pkg::level_t   from_above,
    input  swsm_pkg::level_t   from_below,
    output swsm_pkg::level_t   level
);

    swsm_pkg::level_t level_reg;

    // push moves everything one level deeper, pop moves it back up
    always_ff @(posedge clk)
    begin
        if (shift.push)
        begin
            level_reg <= from_above;
        end
        else if (shift.pop)
        begin
            level_reg <= from_below;
        end
    end

    assign level = level_reg;

endmodule

@@ rtl/core/swsm_level_calc.sv @@
// derives the new top level from the current top and the pushed value
// depends on swsm_pkg

module swsm_level_calc (
    input  swsm_pkg::level_t top,
    input  logic             have_top,
    input  swsm_pkg::value_t value,
    output swsm_pkg::level_t new_level
);

    always_comb
    begin
        new_level = top;
        if (!have_top)
        begin
            new_level.max    = value;
            new_level.second = '0;
            new_level.valid  = 1'b0;
        end
        else if (value > top.max)
        begin
            new_level.max    = value;
            new_level.second = top.max;
            new_level.valid  = 1'b1;
        end
        else if (value < top.max && (!top.valid || value > top.second))
        begin
            new_level.second = value;
            new_level.valid  = 1'b1;
        end
        // equal to max or not above second: copy the top level
    end

endmodule

@@ rtl/core/stack_with_second_max.sv @@
// bounded stack reporting its largest and second-largest distinct value
// the result item is registered at the edge that takes the request
// throughput: one item per cycle, set by the shift of the level chain;
// a result item held by rsp_stall stalls the request side until it leaves
// reset clears the level count and the output valid; level contents stay undefined
// depends on swsm_pkg, swsm_cell, swsm_level_calc

module stack_with_second_max (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  swsm_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output swsm_pkg::rsp_t rsp
);

    localparam int DEPTH = swsm_pkg::DEPTH;

    swsm_pkg::count_t     count_reg, count_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    swsm_pkg::rsp_t       rsp_reg, rsp_next;

    swsm_pkg::level_t     level_q [DEPTH];
    swsm_pkg::level_t     above   [DEPTH];
    swsm_pkg::level_t     below   [DEPTH];
    swsm_pkg::level_t     new_level, next_top;
    swsm_pkg::shift_ctl_t shift;

    logic accept, full, empty, do_push, do_pop;

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;
    assign full      = (count_reg == swsm_pkg::COUNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign do_push   = accept && (req.opcode == swsm_pkg::OP_PUSH) && !full;
    assign do_pop    = accept && (req.opcode == swsm_pkg::OP_POP) && !empty;

    assign shift.push = do_push;
    assign shift.pop  = do_pop;

    swsm_level_calc u_calc (
        .top       (level_q[0]),
        .have_top  (!empty),
        .value     (req.push_value),
        .new_level (new_level)
    );

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            if (i == 0)
            begin : g_first
                assign above[i] = new_level;
            end
            else
            begin : g_mid
                assign above[i] = level_q[i-1];
            end
            if (i == DEPTH - 1)
            begin : g_last
                assign below[i] = level_q[i];
            end
            else
            begin : g_rest
                assign below[i] = level_q[i+1];
            end

            swsm_cell u_cell (
                .clk        (clk),
                .shift      (shift),
                .from_above (above[i]),
                .from_below (below[i]),
                .level      (level_q[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        next_top       = level_q[0];

        if (do_push)
        begin
            count_next = count_reg + swsm_pkg::COUNT_W'(1);
            next_top   = new_level;
        end
        else if (do_pop)
        begin
            count_next = count_reg - swsm_pkg::COUNT_W'(1);
            next_top   = level_q[1];
        end

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        if (accept)
        begin
            rsp_valid_next = 1'b1;
            if (count_next == '0)
            begin
                rsp_next.top_max      = '0;
                rsp_next.top_second   = '0;
                rsp_next.second_valid = 1'b0;
                rsp_next.is_empty     = 1'b1;
            end
            else
            begin
                rsp_next.top_max      = next_top.max;
                rsp_next.top_second   = next_top.valid ? next_top.second : '0;
                rsp_next.second_valid = next_top.valid;
                rsp_next.is_empty     = 1'b0;
            end
            if (req.opcode == swsm_pkg::OP_PUSH && full)
            begin
                rsp_next.status = swsm_pkg::STATUS_FULL;
            end
            else if (req.opcode == swsm_pkg::OP_POP && empty)
            begin
                rsp_next.status = swsm_pkg::STATUS_EMPTY;
            end
            else
            begin
                rsp_next.status = swsm_pkg::STATUS_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
